[design/mlfq_pkg.sv]
// Shared types and constants for the feedback queue scheduler.
// No dependencies; used by every module of the block except mlfq_ram.
`timescale 1ns / 1ps
`default_nettype none
package mlfq_pkg;

  localparam int ID_W    = 8;
  localparam int TIME_W  = 24;
  localparam int SLICE_W = 16;
  localparam int TICK_W  = 10;
  localparam int OLVL_W  = 2;
  localparam int REG_W   = 32;
  localparam int PADDR_W = 4;

  localparam int MAX_TASKS_DEF  = 16;
  localparam int NUM_LEVELS_DEF = 3;

  localparam logic [SLICE_W-1:0] SLICE0_RST = SLICE_W'(500);
  localparam logic [SLICE_W-1:0] SLICE1_RST = SLICE_W'(1000);
  localparam logic [SLICE_W-1:0] SLICE2_RST = SLICE_W'(2000);
  localparam logic [TICK_W-1:0]  TICK_RST   = TICK_W'(10);

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_SLICE0 = 2'd0,
    REG_SLICE1 = 2'd1,
    REG_SLICE2 = 2'd2,
    REG_TICK   = 2'd3
  } reg_idx_t;

  typedef enum logic {
    CMD_ADMIT = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [SLICE_W-1:0] slice0;
    logic [SLICE_W-1:0] slice1;
    logic [SLICE_W-1:0] slice2;
    logic [TICK_W-1:0]  tick_len;
  } cfg_t;

  typedef struct packed {
    cmd_t              command;
    logic [ID_W-1:0]   task_id;
    logic [TIME_W-1:0] total_time;
  } item_t;

  // queue entry as held in memory
  typedef struct packed {
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] total;
    logic [ID_W-1:0]   id;
  } entry_t;

  typedef struct packed {
    logic              admit_rejected;
    logic [ID_W-1:0]   done_task;
    logic              done_valid;
    logic [OLVL_W-1:0] run_level;
    logic [ID_W-1:0]   running_task;
    logic              running_valid;
  } result_t;

  localparam int RES_W  = $bits(result_t);
  localparam int OUT_W  = ((RES_W + 7) / 8) * 8;
  localparam int IN_W   = ID_W + TIME_W;

endpackage
`default_nettype wire

[design/mlfq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module mlfq_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[design/mlfq_cfg.sv]
// APB register file: time slices per level and tick length.
// Depends on mlfq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mlfq_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mlfq_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [mlfq_pkg::REG_W-1:0]    pwdata,
  output logic      [mlfq_pkg::REG_W-1:0]    prdata,
  output logic                               pready,
  output mlfq_pkg::cfg_t                     cfg
);
  import mlfq_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slice0   <= SLICE0_RST;
      cfg.slice1   <= SLICE1_RST;
      cfg.slice2   <= SLICE2_RST;
      cfg.tick_len <= TICK_RST;
    end else if (wr) begin
      unique case (idx)
        REG_SLICE0: cfg.slice0   <= pwdata[SLICE_W-1:0];
        REG_SLICE1: cfg.slice1   <= pwdata[SLICE_W-1:0];
        REG_SLICE2: cfg.slice2   <= pwdata[SLICE_W-1:0];
        REG_TICK:   cfg.tick_len <= pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SLICE0: prdata = REG_W'(cfg.slice0);
      REG_SLICE1: prdata = REG_W'(cfg.slice1);
      REG_SLICE2: prdata = REG_W'(cfg.slice2);
      REG_TICK:   prdata = REG_W'(cfg.tick_len);
      default:    prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

[design/mlfq_core.sv]
// Scheduler sequencer: queue pointers, running-task registers and the
// read-modify-write of the queue entry memory. Depends on mlfq_pkg, mlfq_ram.
`timescale 1ns / 1ps
`default_nettype none
module mlfq_core #(
  parameter int MAX_TASKS  = mlfq_pkg::MAX_TASKS_DEF,
  parameter int NUM_LEVELS = mlfq_pkg::NUM_LEVELS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mlfq_pkg::cfg_t    cfg,
  input  wire logic              in_valid,
  input  wire mlfq_pkg::item_t   in_item,
  output logic                   in_ready,
  output logic                   res_valid,
  output mlfq_pkg::result_t      res,
  input  wire logic              res_ready
);
  import mlfq_pkg::*;

  localparam int PTR_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int LVL_W  = $clog2(NUM_LEVELS);
  localparam int DEPTH  = NUM_LEVELS * MAX_TASKS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] ROW      = ADDR_W'(MAX_TASKS);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(MAX_TASKS - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(MAX_TASKS);
  localparam logic [LVL_W-1:0]  LVL_LAST = LVL_W'(NUM_LEVELS - 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ADV  = 6'b000010,
    S_EVAL = 6'b000100,
    S_PICK = 6'b001000,
    S_LOAD = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t state, state_next;

  item_t             item;
  logic [PTR_W-1:0]  heads  [NUM_LEVELS];
  logic [PTR_W-1:0]  tails  [NUM_LEVELS];
  logic [CNT_W-1:0]  counts [NUM_LEVELS];
  logic [CNT_W-1:0]  task_count;
  logic              cpu_busy;
  logic [ID_W-1:0]   cpu_task_id;
  logic [TIME_W-1:0] cpu_total;
  logic [TIME_W-1:0] cpu_elapsed;
  logic [TIME_W-1:0] cpu_slice_start;
  logic [LVL_W-1:0]  cpu_level;
  logic              done_flag;
  logic [ID_W-1:0]   done_id;
  logic              rejected;
  logic [LVL_W-1:0]  pick_lvl;

  // memory ports
  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  entry_t            wentry, rentry;
  logic [$bits(entry_t)-1:0] rdata;

  function automatic logic [ADDR_W-1:0] row_addr(input logic [LVL_W-1:0] lvl,
                                                 input logic [PTR_W-1:0] ptr);
    return ADDR_W'(lvl) * ROW + ADDR_W'(ptr);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  mlfq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wentry),
    .raddr (raddr),
    .rdata (rdata)
  );
  assign rentry = entry_t'(rdata);

  // elapsed advance, saturating
  logic [TIME_W:0]   el_sum;
  logic [TIME_W-1:0] el_sat;
  assign el_sum = {1'b0, cpu_elapsed} + (TIME_W+1)'(cfg.tick_len);
  assign el_sat = el_sum[TIME_W] ? TIME_MAX : el_sum[TIME_W-1:0];

  // completion / slice expiry
  logic              is_done, is_demote;
  logic [TIME_W-1:0] run_time;
  logic [SLICE_W-1:0] slice;
  logic [LVL_W-1:0]  dem_lvl;
  always_comb begin
    priority if (cpu_level == '0) slice = cfg.slice0;
    else if (cpu_level == LVL_W'(1))  slice = cfg.slice1;
    else                              slice = cfg.slice2;
    run_time  = cpu_elapsed - cpu_slice_start;
    is_done   = cpu_busy && (cpu_elapsed >= cpu_total);
    is_demote = cpu_busy && !is_done && (run_time >= TIME_W'(slice));
    dem_lvl   = (cpu_level == LVL_LAST) ? cpu_level : cpu_level + 1'b1;
  end

  // highest-priority (lowest-numbered) non-empty level
  logic             any_q;
  logic [LVL_W-1:0] sel_lvl;
  always_comb begin
    any_q   = 1'b0;
    sel_lvl = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (counts[i] != '0) begin
        any_q   = 1'b1;
        sel_lvl = LVL_W'(i);
      end
    end
  end

  logic admit_ok;
  assign admit_ok = task_count < CNT_FULL;

  always_comb begin
    we     = 1'b0;
    waddr  = row_addr('0, tails[0]);
    wentry = '{elapsed: '0, total: item.total_time, id: item.task_id};
    if (state == S_ADV && item.command == CMD_ADMIT) begin
      we = admit_ok && (counts[0] < CNT_FULL);
    end else if (state == S_EVAL) begin
      we     = is_demote && (counts[dem_lvl] < CNT_FULL);
      waddr  = row_addr(dem_lvl, tails[dem_lvl]);
      wentry = '{elapsed: cpu_elapsed, total: cpu_total, id: cpu_task_id};
    end
  end

  assign raddr = row_addr(sel_lvl, heads[sel_lvl]);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_ADV;
      S_ADV:  state_next = (item.command == CMD_TICK) ? S_EVAL : S_FIN;
      S_EVAL: state_next = S_PICK;
      S_PICK: state_next = (!cpu_busy && any_q) ? S_LOAD : S_FIN;
      S_LOAD: state_next = S_FIN;
      S_FIN:  if (res_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_FIN);

  always_comb begin
    res.running_valid  = cpu_busy;
    res.running_task   = cpu_busy ? cpu_task_id : '0;
    res.run_level      = cpu_busy ? OLVL_W'(cpu_level) : '0;
    res.done_valid     = done_flag;
    res.done_task      = done_id;
    res.admit_rejected = rejected;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      item <= in_item;
    end
    if (state == S_ADV && item.command == CMD_TICK && cpu_busy) begin
      cpu_elapsed <= el_sat;
    end
    if (state == S_EVAL && is_demote) begin
      cpu_level <= dem_lvl;
    end
    if (state == S_PICK) begin
      pick_lvl <= sel_lvl;
    end
    if (state == S_LOAD) begin
      cpu_task_id     <= rentry.id;
      cpu_total       <= rentry.total;
      cpu_elapsed     <= rentry.elapsed;
      cpu_slice_start <= rentry.elapsed;
      cpu_level       <= pick_lvl;
    end
    if (state == S_IDLE) begin
      done_id <= '0;
    end else if (state == S_EVAL && is_done) begin
      done_id <= cpu_task_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      task_count <= '0;
      cpu_busy   <= 1'b0;
      done_flag  <= 1'b0;
      rejected   <= 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        heads[i]  <= '0;
        tails[i]  <= '0;
        counts[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == S_IDLE && in_valid) begin
        done_flag <= 1'b0;
        rejected  <= 1'b0;
      end
      if (we) begin
        if (state == S_EVAL) begin
          tails[dem_lvl]  <= ptr_inc(tails[dem_lvl]);
          counts[dem_lvl] <= counts[dem_lvl] + 1'b1;
        end else begin
          tails[0]  <= ptr_inc(tails[0]);
          counts[0] <= counts[0] + 1'b1;
        end
      end
      if (state == S_ADV && item.command == CMD_ADMIT) begin
        if (admit_ok) begin
          task_count <= task_count + 1'b1;
        end else begin
          rejected <= 1'b1;
        end
      end
      if (state == S_EVAL) begin
        if (is_done) begin
          done_flag <= 1'b1;
          cpu_busy  <= 1'b0;
          if (task_count != '0) task_count <= task_count - 1'b1;
        end else if (is_demote) begin
          cpu_busy <= 1'b0;
        end
      end
      // pop happens as the read is issued; write-back of the demoted
      // entry landed in the preceding S_EVAL state
      if (state == S_PICK && !cpu_busy && any_q) begin
        heads[sel_lvl]  <= ptr_inc(heads[sel_lvl]);
        counts[sel_lvl] <= counts[sel_lvl] - 1'b1;
      end
      if (state == S_LOAD) begin
        cpu_busy <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[design/mlfq_task_scheduler_unit.sv]
// Top level of the multilevel feedback queue scheduler: stream ports, result
// register, APB registers. Depends on mlfq_pkg, mlfq_cfg, mlfq_core.
// Sequencing: an admit passes ADV and FIN; a tick passes ADV, EVAL, PICK, then LOAD
// when it dispatches (registered read of the queue memory), then FIN.
// The sequencer takes a new item only once the last result has left FIN.
// Reset: synchronous; queues empty, CPU idle, registers at default values.
`timescale 1ns / 1ps
`default_nettype none
module mlfq_task_scheduler_unit #(
  parameter int MAX_TASKS  = mlfq_pkg::MAX_TASKS_DEF,
  parameter int NUM_LEVELS = mlfq_pkg::NUM_LEVELS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // APB configuration
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mlfq_pkg::PADDR_W-1:0] paddr,
  input  wire logic [mlfq_pkg::REG_W-1:0]   pwdata,
  output logic      [mlfq_pkg::REG_W-1:0]   prdata,
  output logic                              pready,
  // input stream
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [mlfq_pkg::IN_W-1:0]    s_tdata,  // task_id[7:0], total_time[31:8]
  input  wire logic                         s_tuser,  // command
  // output stream
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // running_valid[0], running_task[8:1], run_level[10:9], done_valid[11],
  // done_task[19:12], admit_rejected[20], zero fill above
  output logic      [mlfq_pkg::OUT_W-1:0]   m_tdata
);
  import mlfq_pkg::*;

  cfg_t    cfg;
  item_t   item;
  result_t res;
  logic    res_valid, res_ready;

  mlfq_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign item.command    = cmd_t'(s_tuser);
  assign item.task_id    = s_tdata[ID_W-1:0];
  assign item.total_time = s_tdata[ID_W +: TIME_W];

  mlfq_core #(
    .MAX_TASKS  (MAX_TASKS),
    .NUM_LEVELS (NUM_LEVELS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_item   (item),
    .in_ready  (s_tready),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // output register; core may take the next item while this one waits
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= OUT_W'(res);
    end
  end

endmodule
`default_nettype wire

[tb/tb_top.sv]
// Self-checking bench for mlfq_task_scheduler_unit: stream driver, result monitor,
// APB register writes and a transaction-level scheduler predictor. Depends on mlfq_pkg.
`timescale 1ns / 1ps
module tb_top;
  import mlfq_pkg::*;

  localparam int MAX_T       = 16;
  localparam int NUM_LVL     = 3;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_TICKS = 100;

  typedef struct {
    cmd_t              cmd;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] total;
  } sched_cmd_t;

  typedef struct {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] total;
    logic [TIME_W-1:0] elapsed;
  } job_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [REG_W-1:0]   pwdata = '0;
  wire  [REG_W-1:0]   prdata;
  wire                pready;
  logic               s_tvalid = 1'b0;
  wire                s_tready;
  logic [IN_W-1:0]    s_tdata = '0;   // task_id[7:0], total_time[31:8]
  logic               s_tuser = 1'b0; // command
  wire                m_tvalid;
  logic               m_tready = 1'b0;
  // running_valid[0], running_task[8:1], run_level[10:9], done_valid[11],
  // done_task[19:12], admit_rejected[20], zero fill above
  wire  [OUT_W-1:0]   m_tdata;

  mlfq_task_scheduler_unit uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial forever #4 clk = ~clk;

  // scheduler state as predicted
  logic [SLICE_W-1:0] cfg_slice [NUM_LVL];
  logic [TICK_W-1:0]  cfg_tick;
  job_t               lvl_ring [NUM_LVL][MAX_T];
  int                 lvl_head [NUM_LVL];
  int                 lvl_tail [NUM_LVL];
  int                 lvl_count [NUM_LVL];
  int                 held_tasks;
  logic               cpu_on;
  job_t               cpu_job;
  logic [TIME_W-1:0]  cpu_slice_start;
  int                 cpu_lvl;

  sched_cmd_t pending_cmds[$];
  sched_cmd_t in_flight;
  result_t    expected_status[$];
  int         errors = 0;
  int         src_idle_pct = 0;
  int         sink_stall_pct = 0;
  int         hold_reqs = 0;
  int         hold_seen = 0;
  int         hold_left = 0;
  int         quiet_cycles = 0;

  function automatic void queue_push(int lv, job_t j);
    lvl_ring[lv][lvl_tail[lv]] = j;
    lvl_tail[lv] = (lvl_tail[lv] + 1) % MAX_T;
    lvl_count[lv]++;
  endfunction

  function automatic result_t schedule_next(sched_cmd_t c);
    result_t           r;
    logic [TIME_W:0]   sum;
    job_t              j;
    logic              picked;
    r = '0;
    picked = 1'b0;
    if (c.cmd == CMD_ADMIT) begin
      if (held_tasks >= MAX_T) begin
        r.admit_rejected = 1'b1;
      end else begin
        j.id = c.id;
        j.total = c.total;
        j.elapsed = '0;
        queue_push(0, j);
        held_tasks++;
      end
    end else begin
      if (cpu_on) begin
        sum = cpu_job.elapsed + cfg_tick;
        cpu_job.elapsed = (sum > {1'b0, TIME_MAX}) ? TIME_MAX : sum[TIME_W-1:0];
        if (cpu_job.elapsed >= cpu_job.total) begin
          r.done_valid = 1'b1;
          r.done_task = cpu_job.id;
          cpu_on = 1'b0;
          if (held_tasks > 0) held_tasks--;
        end else if (cpu_job.elapsed - cpu_slice_start >= cfg_slice[cpu_lvl]) begin
          if (cpu_lvl < NUM_LVL - 1) cpu_lvl++;
          queue_push(cpu_lvl, cpu_job);
          cpu_on = 1'b0;
        end
      end
      if (!cpu_on) begin
        for (int lv = 0; lv < NUM_LVL; lv++) begin
          if (!picked && lvl_count[lv] != 0) begin
            cpu_job = lvl_ring[lv][lvl_head[lv]];
            lvl_head[lv] = (lvl_head[lv] + 1) % MAX_T;
            lvl_count[lv]--;
            cpu_on = 1'b1;
            cpu_slice_start = cpu_job.elapsed;
            cpu_lvl = lv;
            picked = 1'b1;
          end
        end
      end
    end
    r.running_valid = cpu_on;
    r.running_task  = cpu_on ? cpu_job.id : '0;
    r.run_level     = cpu_on ? OLVL_W'(cpu_lvl) : '0;
    return r;
  endfunction

  // input side: prediction happens when the transfer completes
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) expected_status.push_back(schedule_next(in_flight));
      if (!s_tvalid || s_tready) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_flight = pending_cmds.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= in_flight.cmd;
          s_tdata  <= {in_flight.total, in_flight.id};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // output side: check, then pick next ready (long hold-off on request)
  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[RES_W-1:0]);
        if (expected_status.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
        end else begin
          want = expected_status.pop_front();
          if (got.running_valid !== want.running_valid ||
              got.running_task !== want.running_task ||
              got.run_level !== want.run_level ||
              got.done_valid !== want.done_valid ||
              got.done_task !== want.done_task ||
              got.admit_rejected !== want.admit_rejected ||
              m_tdata[OUT_W-1:RES_W] !== '0) begin
            errors++;
            $display("%0t: mismatch expected run=%0d/%0d/L%0d done=%0d/%0d rej=%0d",
                     $time, want.running_valid, want.running_task, want.run_level,
                     want.done_valid, want.done_task, want.admit_rejected);
            $display("%0t:          actual run=%0d/%0d/L%0d done=%0d/%0d rej=%0d fill=%h",
                     $time, got.running_valid, got.running_task, got.run_level,
                     got.done_valid, got.done_task, got.admit_rejected,
                     m_tdata[OUT_W-1:RES_W]);
          end
        end
      end
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic apb_write(reg_idx_t idx, logic [REG_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SLICE0: cfg_slice[0] = val[SLICE_W-1:0];
      REG_SLICE1: cfg_slice[1] = val[SLICE_W-1:0];
      REG_SLICE2: cfg_slice[2] = val[SLICE_W-1:0];
      REG_TICK:   cfg_tick = val[TICK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int s0, int s1, int s2, int tk);
    apb_write(REG_SLICE0, s0);
    apb_write(REG_SLICE1, s1);
    apb_write(REG_SLICE2, s2);
    apb_write(REG_TICK, tk);
    @(negedge clk);
  endtask

  task automatic push_cmd(cmd_t cmd, logic [ID_W-1:0] id, logic [TIME_W-1:0] total);
    sched_cmd_t c;
    c.cmd = cmd;
    c.id = id;
    c.total = total;
    pending_cmds.push_back(c);
  endtask

  // totals scaled to the tick length so tasks finish and the store keeps turning over
  task automatic push_random(int n, int admit_pct);
    repeat (n) begin
      if ($urandom_range(99) < admit_pct)
        push_cmd(CMD_ADMIT, ID_W'($urandom), TIME_W'($urandom_range(12 * cfg_tick, 0)));
      else
        push_cmd(CMD_TICK, ID_W'($urandom), TIME_W'($urandom));
    end
  endtask

  // block is idle once every result is back; then wait out the pipeline
  task automatic drain();
    while (pending_cmds.size() != 0 || s_tvalid || expected_status.size() != 0)
      @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic set_idle(int src, int sink);
    src_idle_pct = src;
    sink_stall_pct = sink;
  endtask

  initial begin
    int tk;
    cfg_slice[0] = SLICE0_RST;
    cfg_slice[1] = SLICE1_RST;
    cfg_slice[2] = SLICE2_RST;
    cfg_tick = TICK_RST;
    for (int lv = 0; lv < NUM_LVL; lv++) begin
      lvl_head[lv] = 0;
      lvl_tail[lv] = 0;
      lvl_count[lv] = 0;
    end
    held_tasks = 0;
    cpu_on = 1'b0;
    cpu_job.id = '0;
    cpu_job.total = '0;
    cpu_job.elapsed = '0;
    cpu_slice_start = '0;
    cpu_lvl = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, reset config: empty tick, admits without dispatch, zero total,
    // full store and a rejected admit
    push_cmd(CMD_TICK, 8'h00, 24'h000000);
    push_cmd(CMD_ADMIT, 8'h00, 24'h000000);
    push_cmd(CMD_ADMIT, 8'hFF, TIME_MAX);
    push_cmd(CMD_ADMIT, 8'hA5, 24'h000001);
    push_cmd(CMD_TICK, 8'hFF, TIME_MAX);
    push_cmd(CMD_TICK, 8'h5A, 24'h5A5A5A);
    for (int i = 0; i < 14; i++) push_cmd(CMD_ADMIT, ID_W'(8'h10 + i), TIME_W'(100 * i));
    push_cmd(CMD_ADMIT, 8'h5A, 24'hA5A5A5);
    push_cmd(CMD_TICK, 8'h00, 24'h000000);
    drain();

    // run the short tasks out at a long tick; the full-length task stays held
    set_config(65535, 65535, 65535, 1000);
    repeat (DRAIN_TICKS) push_cmd(CMD_TICK, ID_W'($urandom), TIME_W'($urandom));
    drain();

    // smallest settings, demotion on every tick
    set_config(1, 1, 1, 1);
    push_random(80, 30);
    drain();

    tk = $urandom_range(1000, 1);
    set_config($urandom_range(4 * tk, 1), $urandom_range(4 * tk, 1),
               $urandom_range(4 * tk, 1), tk);
    set_idle(52, 0);
    push_random(80, 30);
    drain();

    set_config(65535, 65535, 65535, 1000);
    set_idle(0, 52);
    push_random(80, 30);
    hold_reqs++;
    drain();

    set_config($urandom_range(65535, 1), $urandom_range(65535, 1),
               $urandom_range(65535, 1), $urandom_range(1000, 1));
    set_idle(13, 13);
    push_random(80, 30);
    drain();

    repeat (20) @(posedge clk);
    if (errors == 0 && expected_status.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

[filelist.f]
design/mlfq_pkg.sv
design/mlfq_ram.sv
design/mlfq_cfg.sv
design/mlfq_core.sv
design/mlfq_task_scheduler_unit.sv
tb/tb_top.sv
